### rtl/core/tdar_pkg.sv
// ----------------------------------------------------------------------------
// tdar_pkg
// Shared types, constants and command/status bundles of the table driven
// automaton recognizer.
// ----------------------------------------------------------------------------
package tdar_pkg;

    localparam int STATE_COUNT      = 16;
    localparam int POSITION_BITS    = 16;

    localparam int STATE_FIELD_BITS = 4;
    localparam int LETTER_BITS      = 8;
    localparam int OUT_POS_BITS     = 16;
    localparam int LETTER_COUNT     = 1 << LETTER_BITS;
    localparam int STORE_DEPTH      = STATE_COUNT * LETTER_COUNT;
    localparam int ADDR_BITS        = $clog2(STORE_DEPTH);
    localparam int ENTRY_BITS       = 2 + STATE_FIELD_BITS;

    localparam int S_TDATA_BITS     = 24;
    localparam int M_TDATA_BITS     = 16;

    localparam logic [POSITION_BITS-1:0] POS_LIMIT =
        (POSITION_BITS >= 16) ? POSITION_BITS'(65535) : {POSITION_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_SYMBOL = 2'd1,
        KIND_EMPTY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_REJECT = 2'd1,
        VERDICT_REFUSE = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic                        valid;
        logic                        is_final;
        logic [STATE_FIELD_BITS-1:0] target;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step;
        logic load;
        logic commit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic needs_result;
        logic out_blocked;
    } status_t;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] p);
        sat_inc = (p >= POS_LIMIT) ? POS_LIMIT : p + 1'b1;
    endfunction

endpackage

### rtl/core/tdar_ram.sv
// ----------------------------------------------------------------------------
// tdar_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tdar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/tdar_datapath.sv
// ----------------------------------------------------------------------------
// tdar_datapath
// Transition table, walk registers, table checks and the result register.
// ----------------------------------------------------------------------------
module tdar_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tdar_pkg::cmd_t                     cmd,
    output tdar_pkg::status_t                  status,
    input  logic [tdar_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  logic [1:0]                         s_tuser,
    input  logic                               s_tlast,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [tdar_pkg::M_TDATA_BITS-1:0]  m_tdata,
    output logic [1:0]                         m_tuser
);
    import tdar_pkg::*;

    // Incoming fields.
    logic [STATE_FIELD_BITS-1:0] in_from;
    logic [LETTER_BITS-1:0]      in_letter;
    logic                        in_fin;
    logic [STATE_FIELD_BITS-1:0] in_to;
    kind_t                       in_kind;

    assign in_from   = s_tdata[3:0];
    assign in_letter = s_tdata[11:4];
    assign in_fin    = s_tdata[12];
    assign in_to     = s_tdata[16:13];
    assign in_kind   = kind_t'(s_tuser);

    // Latched item.
    kind_t                       kind_reg;
    logic [STATE_FIELD_BITS-1:0] from_reg;
    logic                        fin_reg;
    logic [STATE_FIELD_BITS-1:0] to_reg;
    logic                        last_reg;
    logic [ADDR_BITS-1:0]        addr_reg;

    // Walk and table state.
    logic [STATE_FIELD_BITS-1:0] cur_state_reg, cur_state_next;
    logic [POSITION_BITS-1:0]    count_reg, count_next;
    logic                        decided_reg, decided_next;
    logic [POSITION_BITS-1:0]    pend_pos_reg, pend_pos_next;
    logic                        pend_acc_reg, pend_acc_next;
    logic                        conflict_reg, conflict_next;
    logic                        final_seen_reg, final_seen_next;
    logic                        start_seen_reg, start_seen_next;
    logic [ADDR_BITS-1:0]        clr_addr_reg;

    // Result register.
    logic                        m_valid_reg;
    logic [1:0]                  m_verdict_reg;
    logic [OUT_POS_BITS-1:0]     m_pos_reg;

    // Table port.
    logic                        ram_wr_en;
    logic [ADDR_BITS-1:0]        ram_wr_addr;
    entry_t                      ram_wr_data;
    logic [ADDR_BITS-1:0]        ram_rd_addr;
    logic [ENTRY_BITS-1:0]       ram_rd_data;

    entry_t                      rd_entry;
    entry_t                      walk_entry;
    entry_t                      new_entry;
    logic                        from_ok;
    logic                        state_ok;
    logic                        res_fire;
    verdict_t                    res_verdict;
    logic [POSITION_BITS-1:0]    res_pos;
    logic                        refused;
    logic                        out_load;

    tdar_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.load),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // A write item reads its own entry first so that a conflict can be seen.
    assign ram_rd_addr = (in_kind == KIND_WRITE) ? ADDR_BITS'({in_from, in_letter})
                                                 : ADDR_BITS'({cur_state_reg, in_letter});

    assign rd_entry  = entry_t'(ram_rd_data);
    assign from_ok   = 32'(from_reg) < STATE_COUNT;
    assign state_ok  = 32'(cur_state_reg) < STATE_COUNT;
    assign walk_entry = state_ok ? rd_entry : entry_t'('0);
    assign new_entry = '{valid: 1'b1, is_final: fin_reg, target: to_reg};

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = new_entry;
        if (cmd.clear_step) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = entry_t'('0);
        end else if (cmd.commit && kind_reg == KIND_WRITE && from_ok) begin
            ram_wr_en   = 1'b1;
        end
    end

    always_comb begin
        cur_state_next  = cur_state_reg;
        count_next      = count_reg;
        decided_next    = decided_reg;
        pend_pos_next   = pend_pos_reg;
        pend_acc_next   = pend_acc_reg;
        conflict_next   = conflict_reg;
        final_seen_next = final_seen_reg;
        start_seen_next = start_seen_reg;
        res_fire        = 1'b0;
        res_verdict     = VERDICT_REJECT;
        res_pos         = '0;
        if (cmd.commit) begin
            unique case (kind_reg)
                KIND_WRITE: begin
                    if (from_ok) begin
                        if (rd_entry.valid && rd_entry != new_entry) begin
                            conflict_next = 1'b1;
                        end
                        if (fin_reg) begin
                            final_seen_next = 1'b1;
                        end
                        if (from_reg == '0) begin
                            start_seen_next = 1'b1;
                        end
                    end
                end
                KIND_SYMBOL: begin
                    if (!decided_reg) begin
                        if (!walk_entry.valid) begin
                            decided_next  = 1'b1;
                            pend_pos_next = count_reg;
                        end else if (walk_entry.is_final) begin
                            decided_next = 1'b1;
                            if (last_reg) begin
                                pend_acc_next = 1'b1;
                            end else begin
                                pend_pos_next = sat_inc(count_reg);
                            end
                        end else begin
                            cur_state_next = walk_entry.target;
                        end
                    end
                    if (last_reg) begin
                        res_fire = 1'b1;
                        if (!decided_next) begin
                            res_pos = sat_inc(count_reg);
                        end else if (pend_acc_next) begin
                            res_verdict = VERDICT_ACCEPT;
                        end else begin
                            res_pos = pend_pos_next;
                        end
                        cur_state_next = '0;
                        count_next     = '0;
                        decided_next   = 1'b0;
                        pend_pos_next  = '0;
                        pend_acc_next  = 1'b0;
                    end else begin
                        count_next = sat_inc(count_reg);
                    end
                end
                KIND_EMPTY: begin
                    res_fire       = 1'b1;
                    cur_state_next = '0;
                    count_next     = '0;
                    decided_next   = 1'b0;
                    pend_pos_next  = '0;
                    pend_acc_next  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // The table checks use the flags as they stand when the verdict is given.
    assign refused  = conflict_reg || !final_seen_reg || !start_seen_reg;
    assign out_load = res_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_state_reg  <= '0;
            count_reg      <= '0;
            decided_reg    <= 1'b0;
            pend_pos_reg   <= '0;
            pend_acc_reg   <= 1'b0;
            conflict_reg   <= 1'b0;
            final_seen_reg <= 1'b0;
            start_seen_reg <= 1'b0;
            clr_addr_reg   <= '0;
            kind_reg       <= KIND_WRITE;
            m_valid_reg    <= 1'b0;
        end else begin
            cur_state_reg  <= cur_state_next;
            count_reg      <= count_next;
            decided_reg    <= decided_next;
            pend_pos_reg   <= pend_pos_next;
            pend_acc_reg   <= pend_acc_next;
            conflict_reg   <= conflict_next;
            final_seen_reg <= final_seen_next;
            start_seen_reg <= start_seen_next;
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load) begin
                kind_reg <= in_kind;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            from_reg <= in_from;
            fin_reg  <= in_fin;
            to_reg   <= in_to;
            last_reg <= s_tlast;
            addr_reg <= ADDR_BITS'({in_from, in_letter});
        end
        if (out_load) begin
            m_verdict_reg <= refused ? VERDICT_REFUSE : res_verdict;
            m_pos_reg     <= refused ? '0 : OUT_POS_BITS'(res_pos);
        end
    end

    assign status.clear_last   = clr_addr_reg == ADDR_BITS'(STORE_DEPTH - 1);
    assign status.needs_result = (kind_reg == KIND_EMPTY) || (kind_reg == KIND_SYMBOL && last_reg);
    assign status.out_blocked  = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pos_reg;
    assign m_tuser  = m_verdict_reg;

endmodule

### rtl/core/tdar_ctrl.sv
// ----------------------------------------------------------------------------
// tdar_ctrl
// Sequencer: clearing pass after reset, item intake and table evaluation.
// ----------------------------------------------------------------------------
module tdar_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic [1:0]          s_tuser,
    output logic                s_tready,
    input  tdar_pkg::status_t   status,
    output tdar_pkg::cmd_t      cmd
);
    import tdar_pkg::*;

    state_t state_reg, state_next;
    logic   kind_known;

    always_comb begin
        unique case (kind_t'(s_tuser))
            KIND_WRITE, KIND_SYMBOL, KIND_EMPTY: kind_known = 1'b1;
            default:                             kind_known = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && kind_known) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // A result waits here until the output register has room.
                if (!(status.needs_result && status.out_blocked)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid && kind_known;
            end
            ST_EVAL: cmd.commit = !(status.needs_result && status.out_blocked);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/table_driven_automaton_recognizer.sv
// ----------------------------------------------------------------------------
// table_driven_automaton_recognizer
// Programmable finite automaton recognizer with a directly indexed
// transition table and one verdict per string.
// ----------------------------------------------------------------------------
// After reset the block sweeps the transition table clean, one entry a cycle,
// over all STATE_COUNT*256 entries (4096 at the default size), s_tready low.
// After that an item is accepted in the idle state, where the table memory
// is read, and is then evaluated: the registered read data is checked and
// the table or walk state is updated. An item of unknown kind is accepted
// and dropped while intake stays open. The next item is accepted back in
// the idle state. A result waits in an output register, so intake is held
// past evaluation only when a new verdict meets an untaken previous one.
// ----------------------------------------------------------------------------
module table_driven_automaton_recognizer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [3:0] from_state, [11:4] letter, [12] to_final, [16:13] to_state
    input  logic [tdar_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // [1:0] kind
    input  logic [1:0]                         s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] error_position
    output logic [tdar_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // [1:0] verdict
    output logic [1:0]                         m_tuser
);
    import tdar_pkg::*;

    cmd_t    cmd;
    status_t status;

    tdar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdar_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/core/tdar_checker.sv
// ----------------------------------------------------------------------------
// tdar_checker
// Port-level checks of the recognizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tdar_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [1:0]                         s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tdar_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input logic [1:0]                         m_tuser
);
    import tdar_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only a rejection carries a position.
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != VERDICT_REJECT |-> m_tdata == '0)
        else $error("nonzero position on accept or refusal");

    // The clearing pass keeps intake closed right after reset.
    a_clear_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("intake open during table clearing");

    // Intake is closed in the cycle after a known item is accepted, while it is evaluated.
    a_eval_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        (s_tuser == KIND_WRITE || s_tuser == KIND_SYMBOL || s_tuser == KIND_EMPTY)
        |=> !s_tready)
        else $error("intake open while an item is evaluated");

endmodule

bind table_driven_automaton_recognizer tdar_checker u_checker (.*);
